[hw/rtl/mesif_ts_pkg.sv]
// Shared types and constants for the MESIF set-associative tag store.
// No dependencies; the interface file and the top level import this package.
package mesif_ts_pkg;

    localparam int SET_BITS  = 6;
    localparam int WAYS      = 4;
    localparam int ADDR_BITS = 48;

    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int OFS_BITS  = 5;
    localparam int SHF_BITS  = $clog2(ADDR_BITS + 1);
    localparam int OP_BITS   = 3;
    localparam int ST_BITS   = 5;

    // Bit positions inside a line state word.
    localparam int ST_M = 0;
    localparam int ST_E = 1;
    localparam int ST_S = 2;
    localparam int ST_V = 3;
    localparam int ST_F = 4;

    localparam logic [ST_BITS-1:0] STATE_E_FILL = ST_BITS'((1 << ST_V) | (1 << ST_E));
    localparam logic [ST_BITS-1:0] STATE_M_FILL = ST_BITS'((1 << ST_V) | (1 << ST_M));
    localparam logic [WAY_BITS-1:0] AGE_OLDEST  = WAY_BITS'(WAYS - 1);

    typedef enum logic [OP_BITS-1:0] {
        OP_LOOKUP    = 3'd0,
        OP_LOAD      = 3'd1,
        OP_STORE     = 3'd2,
        OP_INVAL     = 3'd3,
        OP_SET_STATE = 3'd4
    } t_op;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [ST_BITS-1:0]  state;
        logic [WAY_BITS-1:0] age;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    localparam int ROW_BITS = $bits(t_row);

endpackage

[hw/rtl/mesif_ts_if.sv]
// Handshake channels of the MESIF tag store: request, result and configuration.
// Depends on mesif_ts_pkg for field widths.
interface mesif_ts_req_if import mesif_ts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   op;
    logic [ADDR_BITS-1:0] address;
    logic                 new_m;
    logic                 new_e;
    logic                 new_s;
    logic                 new_v;
    logic                 new_f;

    modport source (output valid, op, address, new_m, new_e, new_s, new_v, new_f,
                    input ready);
    modport sink   (input valid, op, address, new_m, new_e, new_s, new_v, new_f,
                    output ready);
endinterface

interface mesif_ts_rsp_if;
    logic valid;
    logic ready;
    logic tag_hit;
    logic present;
    logic was_modified;
    logic was_exclusive;
    logic was_shared;
    logic was_forward;

    modport source (output valid, tag_hit, present, was_modified, was_exclusive,
                    was_shared, was_forward, input ready);
    modport sink   (input valid, tag_hit, present, was_modified, was_exclusive,
                    was_shared, was_forward, output ready);
endinterface

interface mesif_ts_cfg_if import mesif_ts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFS_BITS-1:0] offset_bits;

    modport source (output valid, offset_bits, input ready);
    modport sink   (input valid, offset_bits, output ready);
endinterface

[hw/rtl/mesif_set_assoc_tag_store.sv]
// Top level of the MESIF set-associative tag store with LRU replacement.
// Depends on mesif_ts_pkg, the channel interfaces in mesif_ts_if and mesif_ts_ram.
//
//   Channel   Direction  Handshake     Carries
//   i_req     in         valid/ready   op, address, new_m/e/s/v/f
//   o_rsp     out        valid/ready   tag_hit, present, was_modified/exclusive/shared/forward
//   i_cfg     in         valid/ready   offset_bits (always ready)
//
// For each request the set row is read from the tag RAM in the cycle the request is
// accepted, and the update stage then compares tags, updates the row and writes it
// back once the output register can take the result.
// Reset is synchronous and active low; it clears the per-way allocated bits in flops,
// so no clearing pass over the RAM is needed. Tag, state and age words of a way are
// only consulted once that way has been allocated.
// A stalled result stays in the output register; the next request is still accepted
// and its result waits in the update stage until the output register frees up.
module mesif_set_assoc_tag_store import mesif_ts_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mesif_ts_req_if.sink   i_req,
    mesif_ts_rsp_if.source o_rsp,
    mesif_ts_cfg_if.sink   i_cfg
);

    // Two-state controller: idle waits for a request, update owns the read row.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_fsm;

    t_fsm r_state, n_state;

    logic [OFS_BITS-1:0] r_offset;

    // Request captured at acceptance.
    logic [OP_BITS-1:0]  r_op;
    logic [SET_BITS-1:0] r_set;
    logic [TAG_BITS-1:0] r_tag;
    logic [ST_BITS-1:0]  r_new;

    // Allocated bit per way, one row per set, cleared by reset.
    logic [WAYS-1:0] r_alloc [NUM_SETS];

    // Output register.
    logic r_out_valid;
    logic r_out_hit;
    logic r_out_present;
    logic r_out_m;
    logic r_out_e;
    logic r_out_s;
    logic r_out_f;

    logic                 req_fire;
    logic                 done;
    logic [ADDR_BITS-1:0] addr_shifted;
    logic [SET_BITS-1:0]  req_set;
    logic [TAG_BITS-1:0]  req_tag;
    logic [ROW_BITS-1:0]  ram_rdata;
    t_row                 rd_row;
    t_row                 wr_row;
    logic [WAYS-1:0]      alloc_row;
    logic [WAYS-1:0]      wr_alloc;
    logic                 row_we;
    logic                 hit;
    logic [WAY_BITS-1:0]  hit_way;
    logic                 free_found;
    logic [WAY_BITS-1:0]  free_way;
    logic [WAY_BITS-1:0]  victim_way;
    logic [WAY_BITS-1:0]  tgt_way;
    logic [WAY_BITS-1:0]  tgt_age;
    logic                 age_all;
    logic [ST_BITS-1:0]   old_state;

    // The offset shift uses the register as given; a large offset pushes both the
    // set index and the tag towards zero.
    assign addr_shifted = i_req.address >> r_offset;
    assign req_set      = addr_shifted[SET_BITS-1:0];
    assign req_tag      = addr_shifted[ADDR_BITS-1:SET_BITS];

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // The update stage finishes once the output register can take its result.
    assign done = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);

    mesif_ts_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (wr_row),
        .i_re    (req_fire),
        .i_raddr (req_set),
        .o_rdata (ram_rdata)
    );

    assign rd_row    = ram_rdata;
    assign alloc_row = r_alloc[r_set];

    // Tag compare, free-way search and victim choice. In a full set the allocated
    // ages are a permutation, so the least recently used way is the one at the top age.
    always_comb begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        victim_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (alloc_row[i] && (rd_row[i].tag == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(i);
            end
            if (!alloc_row[i]) begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(i);
            end
            if (rd_row[i].age == AGE_OLDEST) begin
                victim_way = WAY_BITS'(i);
            end
        end
    end

    assign old_state = hit ? rd_row[hit_way].state : '0;
    assign tgt_way   = hit ? hit_way : (free_found ? free_way : victim_way);
    assign tgt_age   = rd_row[tgt_way].age;
    // Filling a free way ages every allocated way; otherwise only the younger ones.
    assign age_all   = !hit && free_found;

    always_comb begin
        wr_row   = rd_row;
        wr_alloc = alloc_row;
        row_we   = 1'b0;
        case (r_op)
            OP_LOAD, OP_STORE: begin
                for (int i = 0; i < WAYS; i++) begin
                    if ((WAY_BITS'(i) != tgt_way) && alloc_row[i] &&
                        (age_all || (rd_row[i].age < tgt_age))) begin
                        wr_row[i].age = rd_row[i].age + 1'b1;
                    end
                end
                wr_row[tgt_way].age = '0;
                wr_row[tgt_way].tag = r_tag;
                wr_alloc[tgt_way]   = 1'b1;
                if (r_op == OP_STORE) begin
                    wr_row[tgt_way].state = STATE_M_FILL;
                end else if (!hit || !old_state[ST_V]) begin
                    wr_row[tgt_way].state = STATE_E_FILL;
                end
                row_we = done;
            end
            OP_INVAL: begin
                wr_row[hit_way].state[ST_V] = 1'b0;
                row_we = done && hit;
            end
            OP_SET_STATE: begin
                wr_row[hit_way].state = r_new;
                row_we = done && hit;
            end
            default: begin
                row_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= OFS_BITS'(6);
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++) begin
                r_alloc[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_offset <= i_cfg.offset_bits;
            end
            if (row_we) begin
                r_alloc[r_set] <= wr_alloc;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op  <= i_req.op;
            r_set <= req_set;
            r_tag <= req_tag;
            r_new <= {i_req.new_f, i_req.new_v, i_req.new_s, i_req.new_e, i_req.new_m};
        end
        if (done) begin
            r_out_hit     <= hit;
            r_out_present <= hit && old_state[ST_V];
            r_out_m       <= old_state[ST_M];
            r_out_e       <= old_state[ST_E];
            r_out_s       <= old_state[ST_S];
            r_out_f       <= old_state[ST_F];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.tag_hit       = r_out_hit;
    assign o_rsp.present       = r_out_present;
    assign o_rsp.was_modified  = r_out_m;
    assign o_rsp.was_exclusive = r_out_e;
    assign o_rsp.was_shared    = r_out_s;
    assign o_rsp.was_forward   = r_out_f;

    // An accepted request always moves on to the update stage.
    a_fire_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == S_UPD))
        else $error("accepted request did not enter the update stage");

    // The RAM row is only written back while the update stage holds the read data.
    a_we_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_we |-> (r_state == S_UPD))
        else $error("tag RAM written outside the update stage");

    // A load or store leaves its target way allocated and most recently used.
    a_fill_mru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_we && ((r_op == OP_LOAD) || (r_op == OP_STORE))) |->
        (wr_alloc[tgt_way] && (wr_row[tgt_way].age == '0)))
        else $error("filled way is not allocated as most recently used");

    // A miss reports no line state at all.
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |->
        !(r_out_present || r_out_m || r_out_e || r_out_s || r_out_f))
        else $error("miss result carries line state bits");

    // A completed request lands in the output register on the next edge.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_out_valid)
        else $error("finished request produced no result");

endmodule

[hw/rtl/mesif_ts_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No package dependencies.
module mesif_ts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
